// ===== hdl/overlay_priority_compositor_defines.svh =====
// ---------------------------------------------------------------------------
// Overlay priority compositor assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef OVERLAY_PRIORITY_COMPOSITOR_DEFINES_SVH
`define OVERLAY_PRIORITY_COMPOSITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define OPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define OPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/opc_pkg.sv =====
// ---------------------------------------------------------------------------
// Overlay priority compositor package
// Shared types, codes and helpers for controller and datapath.
// ---------------------------------------------------------------------------
package opc_pkg;

  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int MASK_W     = 6;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_MERGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAIN_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_EN  = 1'd1;

  localparam logic [7:0] PRI_EMPTY = 8'hFF;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_EXEC
  } opc_state_t;

  typedef struct packed {
    logic latch;     // capture input item and read the store
    logic clr_step;  // write one empty entry and advance the sweep
    logic exec;      // finish the item and load the result
  } opc_cmd_t;

  typedef struct packed {
    logic is_clear;    // offered item is a clear
    logic sweep_last;  // sweep sits on the last entry
    logic out_free;    // result register can take a new item
  } opc_stat_t;

  // Per-layer bit of a six-bit mask; layers past the mask read as zero
  function automatic logic layer_bit(input logic [MASK_W-1:0] mask, input logic [2:0] lyr);
    logic [7:0] wide;
    wide = {{(8 - MASK_W){1'b0}}, mask};
    return wide[lyr];
  endfunction

endpackage

// ===== hdl/overlay_priority_compositor.sv =====
// ---------------------------------------------------------------------------
// Overlay priority compositor
// Per-pixel overlay store with priority-ordered draw and screen merge.
// ---------------------------------------------------------------------------
// Draw and merge: accept registers the item and the store read; ST_EXEC loads
//   the result once free, where a draw writes back; no new item until then.
// Clear: one store entry per cycle over all 4^CW entries, then an all-zero result.
// Reset: the same sweep runs first with s_tready low; configuration writes
//   are taken throughout. Enables reset to all ones.
module overlay_priority_compositor #(
  parameter int SCREEN_DIM = 256,
  parameter int NUM_LAYERS = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // x, y, color, layer_in, priority_in, cur_main_pri, cur_sub_pri,
  // win_main_mask, win_sub_mask, zero pad
  input  logic [opc_pkg::IN_DATA_W-1:0]   s_tdata,
  // func
  input  logic [opc_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // main_take, sub_take, out_priority, out_layer, out_color, math_enable,
  // zero pad
  output logic [opc_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [opc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [opc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import opc_pkg::*;

  opc_cmd_t  cmd;
  opc_stat_t stat;

  opc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  opc_datapath #(
    .SCREEN_DIM (SCREEN_DIM),
    .NUM_LAYERS (NUM_LAYERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== hdl/opc_ctrl.sv =====
// ---------------------------------------------------------------------------
// Overlay priority compositor controller
// Sequences reset sweep, clear sweep and per-item execution.
// ---------------------------------------------------------------------------
module opc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  opc_pkg::opc_stat_t stat,
  output opc_pkg::opc_cmd_t  cmd
);
  import opc_pkg::*;

  opc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = stat.is_clear ? ST_CLEAR : ST_EXEC;
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

// ===== hdl/opc_datapath.sv =====
// ---------------------------------------------------------------------------
// Overlay priority compositor datapath
// Overlay store, draw update, merge decision and result register.
// ---------------------------------------------------------------------------
module opc_datapath #(
  parameter int SCREEN_DIM = 256,
  parameter int NUM_LAYERS = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [opc_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [opc_pkg::IN_USER_W-1:0]   s_tuser,
  input  logic                            cfg_we,
  input  logic [opc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [opc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [opc_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  opc_pkg::opc_cmd_t               cmd,
  output opc_pkg::opc_stat_t              stat
);
  import opc_pkg::*;

  localparam int CW    = (SCREEN_DIM >= 256) ? 8 : $clog2(SCREEN_DIM);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [10:0] DIM_LIM   = 11'(SCREEN_DIM);
  localparam logic [7:0]  LYR_LIM   = 8'(NUM_LAYERS);
  localparam logic [2:0]  LYR_CLAMP = 3'(NUM_LAYERS - 1);

  // input fields
  logic [1:0]  in_func;
  logic [7:0]  in_x, in_y, in_layer, in_pri, in_cmain, in_csub;
  logic [15:0] in_color;
  logic [5:0]  in_wmain, in_wsub;

  assign in_func  = s_tuser;
  assign in_x     = s_tdata[7:0];
  assign in_y     = s_tdata[15:8];
  assign in_color = s_tdata[31:16];
  assign in_layer = s_tdata[39:32];
  assign in_pri   = s_tdata[47:40];
  assign in_cmain = s_tdata[55:48];
  assign in_csub  = s_tdata[63:56];
  assign in_wmain = s_tdata[69:64];
  assign in_wsub  = s_tdata[75:70];

  // held item
  logic [1:0]    cur_func;
  logic [AW-1:0] cur_addr;
  logic          cur_inside;
  logic [15:0]   cur_color;
  logic [7:0]    cur_layer, cur_pri, cur_cmain, cur_csub;
  logic [5:0]    cur_wmain, cur_wsub;

  logic [5:0] main_en, sub_en;

  logic [7:0]    pri_mem [DEPTH];
  logic [23:0]   lc_mem  [DEPTH];
  logic [7:0]    rd_pri;
  logic [23:0]   rd_lc;
  logic [AW-1:0] sweep;
  logic [AW-1:0] in_addr, pri_addr;
  logic          in_inside;
  logic          pri_we, lc_we;
  logic [7:0]    pri_wdata;

  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data, result;

  assign in_addr   = {in_y[CW-1:0], in_x[CW-1:0]};
  assign in_inside = ({3'b000, in_x} < DIM_LIM) && ({3'b000, in_y} < DIM_LIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      main_en <= 6'h3F;
      sub_en  <= 6'h3F;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAIN_EN: main_en <= cfg_data;
        REG_SUB_EN:  sub_en  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_func   <= in_func;
      cur_addr   <= in_addr;
      cur_inside <= in_inside;
      cur_color  <= in_color;
      cur_layer  <= in_layer;
      cur_pri    <= in_pri;
      cur_cmain  <= in_cmain;
      cur_csub   <= in_csub;
      cur_wmain  <= in_wmain;
      cur_wsub   <= in_wsub;
    end
  end

  // sweep wraps back to zero after the last entry
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.clr_step) begin
      sweep <= sweep + 1'b1;
    end
  end

  // draw update rule
  logic draw_ok;
  assign draw_ok = (cur_func == FUNC_DRAW) && cur_inside &&
                   ((rd_pri == PRI_EMPTY) || ({1'b0, rd_pri[6:0]} <= cur_pri));

  assign pri_we    = cmd.clr_step || (cmd.exec && draw_ok);
  assign lc_we     = cmd.exec && draw_ok;
  assign pri_addr  = cmd.clr_step ? sweep : cur_addr;
  assign pri_wdata = cmd.clr_step ? PRI_EMPTY : cur_pri;

  always_ff @(posedge clk) begin
    if (pri_we) begin
      pri_mem[pri_addr] <= pri_wdata;
    end
    if (cmd.latch) begin
      rd_pri <= pri_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (lc_we) begin
      lc_mem[cur_addr] <= {cur_color, cur_layer};
    end
    if (cmd.latch) begin
      rd_lc <= lc_mem[in_addr];
    end
  end

  // merge decision
  logic [7:0]  st_layer;
  logic [15:0] st_color;
  logic        merge_hit, lyr_ok, men, sen, wm, ws, main_take, sub_take;
  logic [6:0]  pri7;
  logic [2:0]  lyr_out;

  always_comb begin
    st_layer  = rd_lc[7:0];
    st_color  = rd_lc[23:8];
    pri7      = rd_pri[6:0];
    merge_hit = (cur_func == FUNC_MERGE) && cur_inside &&
                (rd_pri != PRI_EMPTY) && !st_layer[7];
    lyr_ok    = st_layer < LYR_LIM;
    if (lyr_ok) begin
      lyr_out = st_layer[2:0];
      men     = layer_bit(main_en, st_layer[2:0]);
      sen     = layer_bit(sub_en, st_layer[2:0]);
      wm      = layer_bit(cur_wmain, st_layer[2:0]);
      ws      = layer_bit(cur_wsub, st_layer[2:0]);
    end else begin
      // out-of-range layer: main only, windows ignored
      lyr_out = LYR_CLAMP;
      men     = 1'b1;
      sen     = 1'b0;
      wm      = 1'b0;
      ws      = 1'b0;
    end
    main_take = men && !wm && (cur_cmain < {1'b0, pri7});
    sub_take  = sen && !ws && (cur_csub < {1'b0, pri7});
    result    = '0;
    if (merge_hit) begin
      result = {3'b000, !rd_pri[7], st_color, lyr_out, pri7, sub_take, main_take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data <= result;
    end
  end

  assign m_tvalid        = out_valid;
  assign m_tdata         = out_data;
  assign stat.is_clear   = (in_func == FUNC_CLEAR);
  assign stat.sweep_last = (sweep == AW'(DEPTH - 1));
  assign stat.out_free   = !out_valid || m_tready;

endmodule

// ===== hdl/opc_checker.sv =====
// ---------------------------------------------------------------------------
// Overlay priority compositor checker
// Port-level properties, bound to the top level.
// ---------------------------------------------------------------------------
`include "overlay_priority_compositor_defines.svh"

module opc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [opc_pkg::OUT_DATA_W-1:0] m_tdata
);

  `OPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `OPC_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
  `OPC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
  `OPC_ASSERT_NOW(a_take_pri, m_tvalid && (m_tdata[0] || m_tdata[1]), m_tdata[8:2] != 7'd0,
                  "take flagged with zero overlay priority")

endmodule

bind overlay_priority_compositor opc_checker u_opc_checker (.*);
